FILE: src/lcwr_pkg.sv
`timescale 1ns / 1ps

package lcwr_pkg;

   // Field and register widths fixed by the interface.
   localparam int WEIGHT_W   = 24;
   localparam int OFFSET_W   = 24;
   localparam int DEN_W      = 16;
   localparam int COUNT_W    = 8;
   localparam int DELAY_W    = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_RAW_OFFSET       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNTS_PER_GRAM  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARE_GRAMS       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_POWER_DOWN_TICKS = 3'd4;

   // Register reset values.
   localparam logic [OFFSET_W-1:0] RST_RAW_OFFSET       = 24'd0;
   localparam logic [DEN_W-1:0]    RST_COUNTS_PER_GRAM  = 16'd1;
   localparam logic [COUNT_W-1:0]  RST_SAMPLE_COUNT     = 8'd10;
   localparam logic [DEN_W-1:0]    RST_TARE_GRAMS       = 16'd475;
   localparam logic [DELAY_W-1:0]  RST_POWER_DOWN_TICKS = 24'd3000080;

   // Saturation limits.
   localparam int AVG_MAX    = 8388607;
   localparam int AVG_MIN    = -8388608;
   localparam int WEIGHT_MAX = 16777215;

   typedef struct packed {
      logic start_req;
      logic dt_level;
   } req_type;

   typedef struct packed {
      logic                       sck_level;
      logic                       busy_res;
      logic                       weight_valid;
      logic [WEIGHT_W-1:0]        weight_grams;
      logic signed [WEIGHT_W-1:0] raw_average;
   } rsp_type;

   // Phase of the serial converter protocol, advanced at most once per tick.
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_WAIT,
      PH_HIGH,
      PH_LOW,
      PH_POWER
   } phase_type;

   // Sequencer for the result computation.
   typedef enum logic [2:0] {
      SEQ_READY,
      SEQ_AVG_GO,
      SEQ_AVG_WAIT,
      SEQ_SCALE_GO,
      SEQ_SCALE_WAIT,
      SEQ_OUT
   } seq_type;

   typedef enum logic {
      DIV_AVG,
      DIV_SCALE
   } div_sel_type;

   typedef struct packed {
      logic        clear_meas;
      logic        shift_bit;
      logic        end_sample;
      logic        clear_delay;
      logic        inc_delay;
      logic        div_start;
      div_sel_type div_sel;
      logic        take_avg;
      logic        take_weight;
      logic        rsp_load;
      logic        rsp_sck;
      logic        rsp_busy;
      logic        rsp_valid;
   } ctrl_cmd_type;

   typedef struct packed {
      logic bit_last;
      logic last_sample;
      logic delay_done;
      logic div_done;
   } dp_stat_type;

endpackage

FILE: src/lcwr_div.sv
`timescale 1ns / 1ps

module lcwr_div import lcwr_pkg::*; #(
   parameter int DIV_W = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [DIV_W-1:0] dividend,
   input  logic [DEN_W-1:0]        divisor,
   output logic                    done,
   output logic signed [DIV_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               neg_ff, neg_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [DEN_W-1:0]   rem_ff, rem_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [DIV_W-1:0]   quo_ff, quo_in;
   logic [DEN_W:0]     rem_shift;
   logic [DEN_W:0]     trial;

   // One restoring step per cycle on the magnitude; sign applied at the end.
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      neg_in    = neg_ff;
      count_in  = count_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      quo_in    = quo_ff;
      rem_shift = {rem_ff, quo_ff[DIV_W-1]};
      trial     = rem_shift - {1'b0, den_ff};
      if (start) begin
         busy_in  = 1'b1;
         neg_in   = dividend[DIV_W-1];
         count_in = CNT_W'(DIV_W);
         rem_in   = '0;
         den_in   = divisor;
         quo_in   = dividend[DIV_W-1] ? (~dividend + 1'b1) : dividend;
      end else if (busy_ff) begin
         if (!trial[DEN_W]) begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[DEN_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

FILE: src/lcwr_dp.sv
`timescale 1ns / 1ps

module lcwr_dp import lcwr_pkg::*; #(
   parameter int RAW_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  dt_level,
   input  ctrl_cmd_type          cmd,
   output dp_stat_type           stat,
   output rsp_type               rsp_data
);

   localparam int SUM_W = RAW_BITS + COUNT_W;
   localparam int DIV_W = (SUM_W > OFFSET_W + 1) ? SUM_W : OFFSET_W + 1;
   localparam int BIT_W = $clog2(RAW_BITS + 1);

   localparam logic signed [DIV_W-1:0] AVG_HI = DIV_W'(AVG_MAX);
   localparam logic signed [DIV_W-1:0] AVG_LO = DIV_W'(AVG_MIN);
   localparam logic signed [DIV_W:0]   W_HI   = (DIV_W + 1)'(WEIGHT_MAX);

   // Configuration registers.
   logic [OFFSET_W-1:0] raw_offset_ff;
   logic [DEN_W-1:0]    counts_per_gram_ff;
   logic [COUNT_W-1:0]  sample_count_ff;
   logic [DEN_W-1:0]    tare_grams_ff;
   logic [DELAY_W-1:0]  power_down_ticks_ff;

   // Measurement state.
   logic [BIT_W-1:0]           bit_index_ff, bit_index_in;
   logic [RAW_BITS-1:0]        shift_word_ff, shift_word_in;
   logic [COUNT_W-1:0]         sample_index_ff, sample_index_in;
   logic signed [SUM_W-1:0]    raw_sum_ff, raw_sum_in;
   logic [DELAY_W-1:0]         delay_count_ff, delay_count_in;
   logic [WEIGHT_W-1:0]        last_weight_ff, last_weight_in;
   logic signed [WEIGHT_W-1:0] last_average_ff, last_average_in;
   rsp_type                    rsp_ff;

   logic [COUNT_W-1:0]         sample_next;
   logic [COUNT_W-1:0]         count_eff;
   logic [DEN_W-1:0]           cpg_eff;
   logic signed [RAW_BITS-1:0] sample_s;
   logic signed [OFFSET_W:0]   corrected;
   logic signed [DIV_W-1:0]    div_dividend;
   logic [DEN_W-1:0]           div_divisor;
   logic                       div_done;
   logic signed [DIV_W-1:0]    div_quotient;
   logic signed [DIV_W:0]      net_weight;

   // Configuration writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_offset_ff       <= RST_RAW_OFFSET;
         counts_per_gram_ff  <= RST_COUNTS_PER_GRAM;
         sample_count_ff     <= RST_SAMPLE_COUNT;
         tare_grams_ff       <= RST_TARE_GRAMS;
         power_down_ticks_ff <= RST_POWER_DOWN_TICKS;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_RAW_OFFSET:       raw_offset_ff       <= csr_wdata[OFFSET_W-1:0];
            CSR_COUNTS_PER_GRAM:  counts_per_gram_ff  <= csr_wdata[DEN_W-1:0];
            CSR_SAMPLE_COUNT:     sample_count_ff     <= csr_wdata[COUNT_W-1:0];
            CSR_TARE_GRAMS:       tare_grams_ff       <= csr_wdata[DEN_W-1:0];
            CSR_POWER_DOWN_TICKS: power_down_ticks_ff <= csr_wdata[DELAY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Zero counts act as one.
   assign count_eff   = (sample_count_ff == '0) ? COUNT_W'(1) : sample_count_ff;
   assign cpg_eff     = (counts_per_gram_ff == '0) ? DEN_W'(1) : counts_per_gram_ff;
   assign sample_next = (sample_index_ff == '1) ? sample_index_ff : sample_index_ff + 1'b1;
   assign sample_s    = signed'(shift_word_ff);

   assign stat.bit_last    = (bit_index_ff == BIT_W'(RAW_BITS));
   assign stat.last_sample = (sample_next >= count_eff);
   assign stat.delay_done  = (delay_count_ff >= power_down_ticks_ff);
   assign stat.div_done    = div_done;

   // Dividend and divisor for the shared divider.
   assign corrected = {last_average_ff[WEIGHT_W-1], last_average_ff}
                    - {raw_offset_ff[OFFSET_W-1], raw_offset_ff};
   always_comb begin
      if (cmd.div_sel == DIV_SCALE) begin
         div_dividend = DIV_W'(corrected);
         div_divisor  = cpg_eff;
      end else begin
         div_dividend = DIV_W'(raw_sum_ff);
         div_divisor  = {{(DEN_W - COUNT_W){1'b0}}, count_eff};
      end
   end

   lcwr_div #(
      .DIV_W(DIV_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .done    (div_done),
      .quotient(div_quotient)
   );

   assign net_weight = (DIV_W + 1)'(div_quotient) - (DIV_W + 1)'({1'b0, tare_grams_ff});

   // Next values of the measurement state.
   always_comb begin
      bit_index_in    = bit_index_ff;
      shift_word_in   = shift_word_ff;
      sample_index_in = sample_index_ff;
      raw_sum_in      = raw_sum_ff;
      delay_count_in  = delay_count_ff;
      last_weight_in  = last_weight_ff;
      last_average_in = last_average_ff;

      if (cmd.clear_meas) begin
         bit_index_in    = '0;
         shift_word_in   = '0;
         sample_index_in = '0;
         raw_sum_in      = '0;
      end

      // Serial bit capture after the falling clock edge.
      if (cmd.shift_bit) begin
         if (bit_index_ff < BIT_W'(RAW_BITS)) begin
            shift_word_in = {shift_word_ff[RAW_BITS-2:0], dt_level};
         end
         bit_index_in = bit_index_ff + 1'b1;
      end

      // Close out one reading.
      if (cmd.end_sample) begin
         raw_sum_in      = raw_sum_ff + SUM_W'(sample_s);
         bit_index_in    = '0;
         shift_word_in   = '0;
         sample_index_in = sample_next;
      end

      if (cmd.clear_delay) begin
         delay_count_in = '0;
      end else if (cmd.inc_delay) begin
         delay_count_in = delay_count_ff + 1'b1;
      end

      // Saturate the average to the signed field range.
      if (cmd.take_avg) begin
         if (div_quotient > AVG_HI) begin
            last_average_in = WEIGHT_W'(AVG_MAX);
         end else if (div_quotient < AVG_LO) begin
            last_average_in = WEIGHT_W'(AVG_MIN);
         end else begin
            last_average_in = div_quotient[WEIGHT_W-1:0];
         end
      end

      // Clamp the weight at zero and at the field maximum.
      if (cmd.take_weight) begin
         if (net_weight[DIV_W]) begin
            last_weight_in = '0;
         end else if (net_weight > W_HI) begin
            last_weight_in = WEIGHT_W'(WEIGHT_MAX);
         end else begin
            last_weight_in = net_weight[WEIGHT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_index_ff    <= '0;
         shift_word_ff   <= '0;
         sample_index_ff <= '0;
         raw_sum_ff      <= '0;
         delay_count_ff  <= '0;
         last_weight_ff  <= '0;
         last_average_ff <= '0;
      end else begin
         bit_index_ff    <= bit_index_in;
         shift_word_ff   <= shift_word_in;
         sample_index_ff <= sample_index_in;
         raw_sum_ff      <= raw_sum_in;
         delay_count_ff  <= delay_count_in;
         last_weight_ff  <= last_weight_in;
         last_average_ff <= last_average_in;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.sck_level    <= cmd.rsp_sck;
         rsp_ff.busy_res     <= cmd.rsp_busy;
         rsp_ff.weight_valid <= cmd.rsp_valid;
         rsp_ff.weight_grams <= last_weight_ff;
         rsp_ff.raw_average  <= last_average_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: src/lcwr_ctrl.sv
`timescale 1ns / 1ps

module lcwr_ctrl import lcwr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type      req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output ctrl_cmd_type cmd,
   input  dp_stat_type  stat
);

   phase_type phase_ff, phase_in;
   seq_type   seq_ff, seq_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         seq_ff       <= SEQ_READY;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((seq_ff == SEQ_READY) && out_free);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      phase_in     = phase_ff;
      seq_in       = seq_ff;
      cmd          = '0;
      cmd.div_sel  = DIV_AVG;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (seq_ff)
         SEQ_READY: begin
            if (accept) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_busy = 1'b1;
               case (phase_ff)
                  PH_WAIT: begin
                     if (!req_data.dt_level) begin
                        phase_in = PH_HIGH;
                     end
                  end
                  PH_HIGH: begin
                     cmd.rsp_sck = 1'b1;
                     phase_in    = PH_LOW;
                  end
                  PH_LOW: begin
                     cmd.shift_bit = 1'b1;
                     if (stat.bit_last) begin
                        cmd.end_sample = 1'b1;
                        if (stat.last_sample) begin
                           // The response waits for the average and weight.
                           cmd.rsp_load    = 1'b0;
                           cmd.clear_delay = 1'b1;
                           phase_in        = PH_POWER;
                           seq_in          = SEQ_AVG_GO;
                        end else begin
                           phase_in = PH_WAIT;
                        end
                     end else begin
                        phase_in = PH_HIGH;
                     end
                  end
                  PH_POWER: begin
                     if (!stat.delay_done) begin
                        cmd.rsp_sck   = 1'b1;
                        cmd.inc_delay = 1'b1;
                     end else begin
                        phase_in = PH_IDLE;
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                     if (req_data.start_req) begin
                        cmd.clear_meas = 1'b1;
                        phase_in       = PH_WAIT;
                     end else begin
                        cmd.rsp_busy = 1'b0;
                     end
                  end
               endcase
            end
         end
         SEQ_AVG_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_AVG;
            seq_in        = SEQ_AVG_WAIT;
         end
         SEQ_AVG_WAIT: begin
            if (stat.div_done) begin
               cmd.take_avg = 1'b1;
               seq_in       = SEQ_SCALE_GO;
            end
         end
         SEQ_SCALE_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SCALE;
            seq_in        = SEQ_SCALE_WAIT;
         end
         SEQ_SCALE_WAIT: begin
            cmd.div_sel = DIV_SCALE;
            if (stat.div_done) begin
               cmd.take_weight = 1'b1;
               seq_in          = SEQ_OUT;
            end
         end
         SEQ_OUT: begin
            if (out_free) begin
               cmd.rsp_load  = 1'b1;
               cmd.rsp_busy  = 1'b1;
               cmd.rsp_valid = 1'b1;
               seq_in        = SEQ_READY;
            end
         end
         default: begin
            seq_in = SEQ_READY;
         end
      endcase

      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // No request is taken while a result is being computed.
   a_no_accept_while_computing: assert property (@(posedge clock) disable iff (reset)
      (seq_ff != SEQ_READY) |-> req_stall)
      else $error("request accepted while the result sequencer is busy");

   // The divider only finishes while the sequencer waits for it.
   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      stat.div_done |-> (seq_ff == SEQ_AVG_WAIT || seq_ff == SEQ_SCALE_WAIT))
      else $error("divider finished outside a wait state");

   // A finished result is posted and leaves the block in power-down.
   a_result_posted: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SEQ_OUT && out_free) |=> (rsp_valid && phase_ff == PH_POWER))
      else $error("weight result not posted in power-down phase");

endmodule

FILE: src/load_cell_weight_reader.sv
`timescale 1ns / 1ps

// Channel  Direction  Ports                               Moves
// req      in         req_valid, req_stall, req_data      one tick: start_req, dt_level
// rsp      out        rsp_valid, rsp_stall, rsp_data      one tick result per request
// csr      in         csr_wr_en, csr_index, csr_wdata     register writes, no read-back
//
// An ordinary tick's response sits in an output register. The tick that closes the last
// sample waits for the one-bit-per-cycle divider (DIV_W = 32 for 24-bit readings), run
// for the average and then the scale; no request is taken until its result is posted.
// Reset is synchronous and active high; it loads the register defaults and idles the block.
// A stalled response holds; a new request is taken in the same cycle the old one leaves.
module load_cell_weight_reader import lcwr_pkg::*; #(
   parameter int RAW_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   lcwr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .cmd      (cmd),
      .stat     (stat)
   );

   lcwr_dp #(
      .RAW_BITS(RAW_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .dt_level (req_data.dt_level),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule
